// File: rtl/core/colorkey_565_to_rgba_bbox_top_assert.svh
// Assertion macros for the color-key converter.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef COLORKEY_565_TO_RGBA_BBOX_TOP_ASSERT_SVH
`define COLORKEY_565_TO_RGBA_BBOX_TOP_ASSERT_SVH

// Same-cycle implication.
`define CKB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CKB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ckb_pkg.sv
package ckb_pkg;

	localparam int PIXEL_W      = 16;
	localparam int RGBA_W       = 32;
	localparam int LINE_WIDTH_W = 12;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 1;

	localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 12'd640;
	localparam logic [PIXEL_W-1:0]      KEY_COLOR_RST  = 16'h07FF;
	localparam logic [RGBA_W-1:0]       TRANSPARENT_WORD = 32'hFFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_WIDTH = 1'b0,
		CFG_KEY_COLOR  = 1'b1
	} cfg_reg_t;

	// RGB565 to the packed word: blue 23:19, green 15:10, red 7:3, alpha byte 31:24 zero
	function automatic logic [RGBA_W-1:0] convert_pixel(input logic [PIXEL_W-1:0] p);
		convert_pixel = {8'h00, p[4:0], 3'b000, p[10:5], 2'b00, p[15:11], 3'b000};
	endfunction

endpackage

// File: rtl/core/ckb_ifs.sv
interface ckb_pix_in_if import ckb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;
	logic               frame_end;

	modport source (output valid, pixel, frame_end, input ready);
	modport sink   (input valid, pixel, frame_end, output ready);
endinterface

interface ckb_pix_out_if import ckb_pkg::*; #(
	parameter int XW = 11,
	parameter int YW = 11
) ();
	logic              valid;
	logic              ready;
	logic [RGBA_W-1:0] rgba;
	logic              done_res;
	logic              drawn;
	logic [XW-1:0]     box_left;
	logic [YW-1:0]     box_top;
	logic [XW:0]       box_right;
	logic [YW:0]       box_bottom;

	modport source (output valid, rgba, done_res, drawn, box_left, box_top, box_right,
		box_bottom, input ready);
	modport sink   (input valid, rgba, done_res, drawn, box_left, box_top, box_right,
		box_bottom, output ready);
endinterface

interface ckb_cfg_if import ckb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/colorkey_565_to_rgba_bbox_top.sv
// An accepted beat passes the input register, then the result register.
// Throughput: one pixel per clock unless pix_out.ready stalls. The two
// registers form a two-deep queue; with a result waiting, only an empty input stage fills.
// Reset: counters and bounding box clear, line_width returns to 640 and
// key_color to 0x07FF; both queue stages empty.
`include "colorkey_565_to_rgba_bbox_top_assert.svh"

module colorkey_565_to_rgba_bbox_top import ckb_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input logic           clk,
	input logic           arst_n,
	ckb_cfg_if.sink       cfg,
	ckb_pix_in_if.sink    pix_in,
	ckb_pix_out_if.source pix_out
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int CW = (XW + 1 > LINE_WIDTH_W + 1) ? XW + 1 : LINE_WIDTH_W + 1;

	// configuration registers
	logic [LINE_WIDTH_W-1:0] line_width_q;
	logic [PIXEL_W-1:0]      key_color_q;

	// frame state
	logic [XW-1:0] col_q, least_x_q, most_x_q;
	logic [YW-1:0] row_q, least_y_q, most_y_q;
	logic          any_drawn_q;

	// input stage
	logic               valid_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	logic               frame_end_s1;

	// result stage
	logic              valid_s2;
	logic [RGBA_W-1:0] rgba_s2;
	logic              done_s2, drawn_s2;
	logic [XW-1:0]     left_s2;
	logic [YW-1:0]     top_s2;
	logic [XW:0]       right_s2;
	logic [YW:0]       bottom_s2;

	logic          advance, key_hit, lw_bad, col_wrap, row_wrap;
	logic [CW-1:0] limit, col_inc;
	logic [YW:0]   row_inc;
	logic [XW-1:0] least_x_n, most_x_n;
	logic [YW-1:0] least_y_n, most_y_n;
	logic          any_drawn_n;

	// handshakes
	assign cfg.ready    = 1'b1;
	assign advance      = valid_s1 && (!valid_s2 || pix_out.ready);
	assign pix_in.ready = !valid_s1 || advance;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			key_color_q  <= KEY_COLOR_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_LINE_WIDTH: line_width_q <= cfg.data[LINE_WIDTH_W-1:0];
				CFG_KEY_COLOR:  key_color_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.ready && pix_in.valid) begin
			pixel_s1     <= pix_in.pixel;
			frame_end_s1 <= pix_in.frame_end;
		end
	end

	// key match and box update
	always_comb begin
		key_hit     = (pixel_s1 == key_color_q);
		least_x_n   = least_x_q;
		least_y_n   = least_y_q;
		most_x_n    = most_x_q;
		most_y_n    = most_y_q;
		any_drawn_n = any_drawn_q;
		if (!key_hit) begin
			if (col_q < least_x_q) least_x_n = col_q;
			if (row_q < least_y_q) least_y_n = row_q;
			if (col_q > most_x_q)  most_x_n  = col_q;
			if (row_q > most_y_q)  most_y_n  = row_q;
			any_drawn_n = 1'b1;
		end
	end

	// position advance with line and frame wrap
	assign lw_bad   = (line_width_q == '0) || (CW'(line_width_q) > CW'(MAX_WIDTH));
	assign limit    = lw_bad ? CW'(MAX_WIDTH) : CW'(line_width_q);
	assign col_inc  = CW'(col_q) + CW'(1);
	assign col_wrap = (col_inc >= limit);
	assign row_inc  = {1'b0, row_q} + (YW+1)'(1);
	assign row_wrap = (row_inc >= (YW+1)'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			least_x_q   <= '1;
			least_y_q   <= '1;
			most_x_q    <= '0;
			most_y_q    <= '0;
			any_drawn_q <= 1'b0;
		end else if (advance) begin
			if (frame_end_s1) begin
				col_q       <= '0;
				row_q       <= '0;
				least_x_q   <= '1;
				least_y_q   <= '1;
				most_x_q    <= '0;
				most_y_q    <= '0;
				any_drawn_q <= 1'b0;
			end else begin
				least_x_q   <= least_x_n;
				least_y_q   <= least_y_n;
				most_x_q    <= most_x_n;
				most_y_q    <= most_y_n;
				any_drawn_q <= any_drawn_n;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_inc[YW-1:0];
				end else begin
					col_q <= col_inc[XW-1:0];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || pix_out.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rgba_s2   <= key_hit ? TRANSPARENT_WORD : convert_pixel(pixel_s1);
			done_s2   <= frame_end_s1;
			drawn_s2  <= frame_end_s1 && any_drawn_n;
			left_s2   <= (frame_end_s1 && any_drawn_n) ? least_x_n : '0;
			top_s2    <= (frame_end_s1 && any_drawn_n) ? least_y_n : '0;
			right_s2  <= (frame_end_s1 && any_drawn_n) ?
				({1'b0, most_x_n} + (XW+1)'(1)) : '0;
			bottom_s2 <= (frame_end_s1 && any_drawn_n) ?
				({1'b0, most_y_n} + (YW+1)'(1)) : '0;
		end
	end

	assign pix_out.valid      = valid_s2;
	assign pix_out.rgba       = rgba_s2;
	assign pix_out.done_res   = done_s2;
	assign pix_out.drawn      = drawn_s2;
	assign pix_out.box_left   = left_s2;
	assign pix_out.box_top    = top_s2;
	assign pix_out.box_right  = right_s2;
	assign pix_out.box_bottom = bottom_s2;

	// checks
	`CKB_ASSERT_NOW(a_box_only_on_done, valid_s2 && !done_s2,
		!drawn_s2 && left_s2 == '0 && top_s2 == '0 && right_s2 == '0 && bottom_s2 == '0,
		"box fields set on a result that does not close the frame")
	`CKB_ASSERT_NOW(a_box_ordered, valid_s2 && drawn_s2,
		right_s2 > {1'b0, left_s2} && bottom_s2 > {1'b0, top_s2},
		"bounding box upper bound not above lower bound")
	`CKB_ASSERT_NEXT(a_frame_rearm, advance && frame_end_s1,
		col_q == '0 && row_q == '0 && !any_drawn_q && least_x_q == '1,
		"frame state not cleared after the last pixel")
	`CKB_ASSERT_NEXT(a_drawn_tracked, advance && !key_hit && !frame_end_s1,
		any_drawn_q,
		"drawn pixel not recorded")

endmodule
